@@ src/script_lexical_scanner_defines.svh @@
// ----------------------------------------------------------------------------
// script_lexical_scanner_defines
// Assertion macros shared by the sls_front and sls_queue RTL files.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_LEXICAL_SCANNER_DEFINES_SVH
`define SCRIPT_LEXICAL_SCANNER_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define SLS_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define SLS_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/sls_pkg.sv @@
// ----------------------------------------------------------------------------
// sls_pkg
// Types, token kinds and keyword lookup shared by the scanner modules.
// ----------------------------------------------------------------------------
package sls_pkg;

	localparam int POS_W   = 20;
	localparam int LINE_W  = 20;
	localparam int KIND_W  = 6;
	localparam int ERR_W   = 2;
	localparam int TOK_MAX = 3;   // most tokens one byte can finish
	localparam int TOK_CW  = 2;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = 2;
	localparam int QCNT_W  = 3;
	localparam int KW_LEN  = 6;
	localparam int KW_IW   = 3;
	localparam int TOK_W   = KIND_W + POS_W + POS_W + LINE_W + ERR_W;
	localparam int TDATA_W = ((TOK_W + 7) / 8) * 8;

	localparam logic [POS_W-1:0]  POS_MAX  = '1;
	localparam logic [LINE_W-1:0] LINE_MAX = '1;

	typedef enum logic [KIND_W-1:0] {
		K_LPAREN    = 6'd0,  K_RPAREN    = 6'd1,  K_LBRACE   = 6'd2,  K_RBRACE  = 6'd3,
		K_SEMI      = 6'd4,  K_COMMA     = 6'd5,  K_DOT      = 6'd6,
		K_MINUS     = 6'd7,  K_MINUS_EQ  = 6'd8,  K_PLUS     = 6'd9,  K_PLUS_EQ = 6'd10,
		K_SLASH     = 6'd11, K_SLASH_EQ  = 6'd12, K_DSLASH   = 6'd13,
		K_DSLASH_EQ = 6'd14, K_STAR      = 6'd15, K_STAR_EQ  = 6'd16,
		K_DSTAR     = 6'd17, K_DSTAR_EQ  = 6'd18, K_BANG     = 6'd19, K_BANG_EQ = 6'd20,
		K_EQUAL     = 6'd21, K_EQ_EQ     = 6'd22, K_GT       = 6'd23, K_GE      = 6'd24,
		K_LT        = 6'd25, K_LE        = 6'd26,
		K_IDENT     = 6'd27, K_STRING    = 6'd28, K_NUMBER   = 6'd29,
		K_AND       = 6'd30, K_CLASS     = 6'd31, K_ELSE     = 6'd32, K_FALSE   = 6'd33,
		K_FOR       = 6'd34, K_FN        = 6'd35, K_IF       = 6'd36, K_LET     = 6'd37,
		K_NIL       = 6'd38, K_OR        = 6'd39, K_PRINT    = 6'd40, K_RETURN  = 6'd41,
		K_SUPER     = 6'd42, K_THIS      = 6'd43, K_TRUE     = 6'd44, K_WHILE   = 6'd45,
		K_ERROR     = 6'd46, K_EOF       = 6'd47
	} kind_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE         = 2'd0,
		ERR_UNEXPECTED   = 2'd1,
		ERR_UNTERMINATED = 2'd2
	} err_t;

	typedef struct packed {
		err_t              err;
		logic [LINE_W-1:0] line;
		logic [POS_W-1:0]  length;
		logic [POS_W-1:0]  offset;
		kind_t             kind;
	} tok_t;

	// All tokens finished by one source byte, in emission order from index 0.
	typedef struct packed {
		tok_t [TOK_MAX-1:0] toks;
		logic [TOK_CW-1:0]  cnt;
	} bundle_t;

	function automatic tok_t mk_tok(input kind_t k, input logic [POS_W-1:0] off,
			input logic [POS_W-1:0] len, input logic [LINE_W-1:0] ln, input err_t e);
		tok_t t;
		t.kind   = k;
		t.offset = off;
		t.length = len;
		t.line   = ln;
		t.err    = e;
		return t;
	endfunction

	// w holds the first six identifier bytes, first byte in the top bits.
	function automatic kind_t kw_kind(input logic [8*KW_LEN-1:0] w,
			input logic [KW_IW-1:0] n);
		kind_t k;
		k = K_IDENT;
		case (n)
			3'd2: begin
				if (w[47:32] == "fn")      k = K_FN;
				else if (w[47:32] == "if") k = K_IF;
				else if (w[47:32] == "or") k = K_OR;
			end
			3'd3: begin
				if (w[47:24] == "and")      k = K_AND;
				else if (w[47:24] == "for") k = K_FOR;
				else if (w[47:24] == "let") k = K_LET;
				else if (w[47:24] == "nil") k = K_NIL;
			end
			3'd4: begin
				if (w[47:16] == "else")      k = K_ELSE;
				else if (w[47:16] == "this") k = K_THIS;
				else if (w[47:16] == "true") k = K_TRUE;
			end
			3'd5: begin
				if (w[47:8] == "class")      k = K_CLASS;
				else if (w[47:8] == "false") k = K_FALSE;
				else if (w[47:8] == "print") k = K_PRINT;
				else if (w[47:8] == "super") k = K_SUPER;
				else if (w[47:8] == "while") k = K_WHILE;
			end
			3'd6: begin
				if (w[47:40] == "r" && w[39:0] == "eturn") k = K_RETURN;
			end
			default: k = K_IDENT;
		endcase
		return k;
	endfunction

endpackage

@@ src/script_lexical_scanner.sv @@
// ----------------------------------------------------------------------------
// script_lexical_scanner
// Streaming lexical scanner: source bytes in, tokens with kind, offset,
// length, line and error code out.
// ----------------------------------------------------------------------------
//  channel  dir  width  contents
//  s_*      in   8      s_tdata[7:0] src_byte, 0 ends the source
//  m_*      out  72     token_kind, token_offset, token_length, token_line,
//                       error_code; m_tlast = last_of_run
//
// Cycles: one source byte is taken per cycle while the token queue has room;
//   tokens leave at one per cycle while m_tready is high, so a byte that finishes
//   k tokens (k <= 3) occupies the output for k transactions. The four-entry
//   group queue absorbs bursts; a byte finishing no token never touches it.
// Path: the token group a byte finishes is written into the queue as the byte
//   is accepted, then loaded into the output register that drives m_*.
// Reset: arst_n clears scan state to offset 0, line 1; no clearing pass.
// Stalls: s_tready drops only when the queue is full; m_tready low holds the
//   output register and the queue keeps filling behind it.
// ----------------------------------------------------------------------------
module script_lexical_scanner (
	input  logic                         clk,
	input  logic                         arst_n,
	// Source bytes
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] src_byte
	// Tokens
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [5:0] token_kind, [25:6] token_offset, [45:26] token_length,
	// [65:46] token_line, [67:66] error_code, [71:68] zero
	output logic [sls_pkg::TDATA_W-1:0]  m_tdata,
	output logic                         m_tlast    // last_of_run
);

	sls_pkg::bundle_t  fr_bundle, q_head;
	logic              fr_push, q_full, q_empty, bk_pop;

	// Accept a byte whenever the queue can take whatever it finishes.
	assign s_tready = !q_full;

	// Front: classify each byte, track mode, position and line.
	sls_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.push     (fr_push),
		.bundle   (fr_bundle)
	);

	// Queue: hold finished token groups until the back end drains them.
	sls_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fr_push),
		.wr_data (fr_bundle),
		.pop     (bk_pop),
		.head    (q_head),
		.full    (q_full),
		.empty   (q_empty)
	);

	// Back: serialize each group, one transaction per token, tlast on the last.
	sls_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.empty    (q_empty),
		.pop      (bk_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

@@ src/sls_front.sv @@
// ----------------------------------------------------------------------------
// sls_front
// Scan one source byte per cycle while in_valid and in_ready are high, and collect the tokens it finishes.
// ----------------------------------------------------------------------------
`include "script_lexical_scanner_defines.svh"

module sls_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [7:0]             in_byte,
	output logic                   push,
	output sls_pkg::bundle_t       bundle
);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LBR   = 8'h7B;
	localparam logic [7:0] CH_RBR   = 8'h7D;

	typedef enum logic [4:0] {
		M_IDLE, M_IDENT, M_NUMI, M_NUMD, M_NUMF, M_STR, M_CMT,
		M_MINUS, M_PLUS, M_SLASH1, M_SLASH2, M_STAR1, M_STAR2,
		M_BANG, M_EQUAL, M_LESS, M_GREATER
	} mode_t;

	mode_t                          mode_q, nxt_mode, op_dbl_mode;
	logic [sls_pkg::POS_W-1:0]      pos_q, begin_q, dot_q;
	logic [sls_pkg::POS_W-1:0]      nxt_pos, nxt_begin, nxt_dot;
	logic [sls_pkg::LINE_W-1:0]     line_q, nxt_line, line_inc;
	logic [sls_pkg::KW_IW-1:0]      cnt_q, nxt_cnt, win_idx;
	logic [7:0]                     win_q [sls_pkg::KW_LEN];
	logic                           win_we;
	logic [sls_pkg::POS_W-1:0]      held, num_len, with_len;
	logic [sls_pkg::POS_W:0]        with_w;
	logic                           acc, consumed, is_digit, is_alpha;
	logic                           is_op, op_has_dbl;
	logic [7:0]                     op_dchar, low_b;
	sls_pkg::kind_t                 op_base, op_eq;
	sls_pkg::tok_t [sls_pkg::TOK_MAX-1:0] toks;
	logic [sls_pkg::TOK_CW-1:0]     n;

	assign acc      = in_valid && in_ready;
	assign low_b    = in_byte | 8'h20;
	assign is_digit = (in_byte >= "0") && (in_byte <= "9");
	assign is_alpha = !in_byte[7] && (low_b >= "a") && (low_b <= "z");
	assign held     = pos_q - begin_q;
	assign num_len  = dot_q - begin_q;
	assign with_w   = {1'b0, pos_q} + {{sls_pkg::POS_W{1'b0}}, 1'b1} - {1'b0, begin_q};
	assign with_len = with_w[sls_pkg::POS_W] ? sls_pkg::POS_MAX
		: with_w[sls_pkg::POS_W-1:0];
	assign line_inc = (line_q == sls_pkg::LINE_MAX) ? line_q
		: line_q + {{(sls_pkg::LINE_W-1){1'b0}}, 1'b1};

	always_comb begin
		nxt_mode    = mode_q;
		nxt_begin   = begin_q;
		nxt_line    = line_q;
		nxt_cnt     = cnt_q;
		nxt_dot     = dot_q;
		win_we      = 1'b0;
		win_idx     = cnt_q;
		consumed    = 1'b0;
		toks        = '0;
		n           = '0;
		is_op       = 1'b0;
		op_has_dbl  = 1'b0;
		op_dbl_mode = M_IDLE;
		op_dchar    = CH_NUL;
		op_base     = sls_pkg::K_MINUS;
		op_eq       = sls_pkg::K_MINUS_EQ;

		// Continue the pending token.
		case (mode_q)
			M_IDENT: begin
				if (is_alpha || is_digit) begin
					consumed = 1'b1;
					if (cnt_q < 3'd6) win_we = 1'b1;
					if (cnt_q < 3'd7) nxt_cnt = cnt_q + 3'd1;
				end else begin
					toks[n] = sls_pkg::mk_tok(sls_pkg::kw_kind({win_q[0], win_q[1], win_q[2],
						win_q[3], win_q[4], win_q[5]}, cnt_q), begin_q, held, line_q,
						sls_pkg::ERR_NONE);
					n = n + 2'd1;
				end
			end
			M_NUMI: begin
				if (is_digit) begin
					consumed = 1'b1;
				end else if (in_byte == CH_DOT) begin
					consumed = 1'b1;
					nxt_dot  = pos_q;
					nxt_mode = M_NUMD;
				end else begin
					toks[n] = sls_pkg::mk_tok(sls_pkg::K_NUMBER, begin_q, held, line_q,
						sls_pkg::ERR_NONE);
					n = n + 2'd1;
				end
			end
			M_NUMD: begin
				if (is_digit) begin
					consumed = 1'b1;
					nxt_mode = M_NUMF;
				end else begin
					// Trailing dot: split into number and dot.
					toks[n] = sls_pkg::mk_tok(sls_pkg::K_NUMBER, begin_q, num_len, line_q,
						sls_pkg::ERR_NONE);
					n = n + 2'd1;
					toks[n] = sls_pkg::mk_tok(sls_pkg::K_DOT, dot_q,
						{{(sls_pkg::POS_W-1){1'b0}}, 1'b1}, line_q, sls_pkg::ERR_NONE);
					n = n + 2'd1;
				end
			end
			M_NUMF: begin
				if (is_digit) begin
					consumed = 1'b1;
				end else begin
					toks[n] = sls_pkg::mk_tok(sls_pkg::K_NUMBER, begin_q, held, line_q,
						sls_pkg::ERR_NONE);
					n = n + 2'd1;
				end
			end
			M_STR: begin
				if (in_byte == CH_NUL) begin
					toks[n] = sls_pkg::mk_tok(sls_pkg::K_ERROR, begin_q, held, line_q,
						sls_pkg::ERR_UNTERMINATED);
					n = n + 2'd1;
				end else if (in_byte == CH_QUOTE) begin
					toks[n] = sls_pkg::mk_tok(sls_pkg::K_STRING, begin_q, with_len, line_q,
						sls_pkg::ERR_NONE);
					n = n + 2'd1;
					consumed = 1'b1;
					nxt_mode = M_IDLE;
				end else begin
					consumed = 1'b1;
					if (in_byte == CH_LF) nxt_line = line_inc;
				end
			end
			M_CMT: consumed = !(in_byte == CH_NUL || in_byte == CH_LF);
			M_MINUS: begin
				is_op = 1'b1; op_base = sls_pkg::K_MINUS; op_eq = sls_pkg::K_MINUS_EQ;
			end
			M_PLUS: begin
				is_op = 1'b1; op_base = sls_pkg::K_PLUS; op_eq = sls_pkg::K_PLUS_EQ;
			end
			M_SLASH1: begin
				is_op = 1'b1; op_base = sls_pkg::K_SLASH; op_eq = sls_pkg::K_SLASH_EQ;
				op_has_dbl = 1'b1; op_dbl_mode = M_SLASH2; op_dchar = CH_SLASH;
			end
			M_SLASH2: begin
				is_op = 1'b1; op_base = sls_pkg::K_DSLASH; op_eq = sls_pkg::K_DSLASH_EQ;
			end
			M_STAR1: begin
				is_op = 1'b1; op_base = sls_pkg::K_STAR; op_eq = sls_pkg::K_STAR_EQ;
				op_has_dbl = 1'b1; op_dbl_mode = M_STAR2; op_dchar = CH_STAR;
			end
			M_STAR2: begin
				is_op = 1'b1; op_base = sls_pkg::K_DSTAR; op_eq = sls_pkg::K_DSTAR_EQ;
			end
			M_BANG: begin
				is_op = 1'b1; op_base = sls_pkg::K_BANG; op_eq = sls_pkg::K_BANG_EQ;
			end
			M_EQUAL: begin
				is_op = 1'b1; op_base = sls_pkg::K_EQUAL; op_eq = sls_pkg::K_EQ_EQ;
			end
			M_LESS: begin
				is_op = 1'b1; op_base = sls_pkg::K_LT; op_eq = sls_pkg::K_LE;
			end
			M_GREATER: begin
				is_op = 1'b1; op_base = sls_pkg::K_GT; op_eq = sls_pkg::K_GE;
			end
			default: consumed = 1'b0;
		endcase

		if (is_op) begin
			if (in_byte == CH_EQ) begin
				toks[n] = sls_pkg::mk_tok(op_eq, begin_q, with_len, line_q,
					sls_pkg::ERR_NONE);
				n = n + 2'd1;
				consumed = 1'b1;
				nxt_mode = M_IDLE;
			end else if (op_has_dbl && in_byte == op_dchar) begin
				consumed = 1'b1;
				nxt_mode = op_dbl_mode;
			end else begin
				toks[n] = sls_pkg::mk_tok(op_base, begin_q, held, line_q, sls_pkg::ERR_NONE);
				n = n + 2'd1;
			end
		end

		// Rescan the byte from idle, or close the source on a NUL.
		if (!consumed) begin
			if (in_byte == CH_NUL) begin
				toks[n] = sls_pkg::mk_tok(sls_pkg::K_EOF, pos_q, '0, line_q,
					sls_pkg::ERR_NONE);
				n = n + 2'd1;
				nxt_mode  = M_IDLE;
				nxt_begin = '0;
				nxt_line  = {{(sls_pkg::LINE_W-1){1'b0}}, 1'b1};
				nxt_cnt   = '0;
				nxt_dot   = '0;
			end else begin
				nxt_mode  = M_IDLE;
				nxt_begin = pos_q;
				if (is_digit) begin
					nxt_mode = M_NUMI;
				end else if (is_alpha) begin
					nxt_mode = M_IDENT;
					win_we   = 1'b1;
					win_idx  = '0;
					nxt_cnt  = 3'd1;
				end else begin
					case (in_byte)
						CH_SPACE, CH_TAB, CH_CR: nxt_mode = M_IDLE;
						CH_LF:    nxt_line = line_inc;
						CH_HASH:  nxt_mode = M_CMT;
						CH_QUOTE: nxt_mode = M_STR;
						CH_MINUS: nxt_mode = M_MINUS;
						CH_PLUS:  nxt_mode = M_PLUS;
						CH_SLASH: nxt_mode = M_SLASH1;
						CH_STAR:  nxt_mode = M_STAR1;
						CH_BANG:  nxt_mode = M_BANG;
						CH_EQ:    nxt_mode = M_EQUAL;
						CH_LT:    nxt_mode = M_LESS;
						CH_GT:    nxt_mode = M_GREATER;
						CH_LPAR, CH_RPAR, CH_LBR, CH_RBR, CH_SEMI, CH_COMMA, CH_DOT: begin
							toks[n] = sls_pkg::mk_tok(
								(in_byte == CH_LPAR)  ? sls_pkg::K_LPAREN :
								(in_byte == CH_RPAR)  ? sls_pkg::K_RPAREN :
								(in_byte == CH_LBR)   ? sls_pkg::K_LBRACE :
								(in_byte == CH_RBR)   ? sls_pkg::K_RBRACE :
								(in_byte == CH_SEMI)  ? sls_pkg::K_SEMI   :
								(in_byte == CH_COMMA) ? sls_pkg::K_COMMA  : sls_pkg::K_DOT,
								pos_q, {{(sls_pkg::POS_W-1){1'b0}}, 1'b1}, line_q,
								sls_pkg::ERR_NONE);
							n = n + 2'd1;
						end
						default: begin
							toks[n] = sls_pkg::mk_tok(sls_pkg::K_ERROR, pos_q,
								{{(sls_pkg::POS_W-1){1'b0}}, 1'b1}, line_q,
								sls_pkg::ERR_UNEXPECTED);
							n = n + 2'd1;
						end
					endcase
				end
			end
		end

		// Advance the position on every non-NUL byte, holding at the top.
		if (in_byte == CH_NUL) nxt_pos = '0;
		else if (pos_q == sls_pkg::POS_MAX) nxt_pos = pos_q;
		else nxt_pos = pos_q + {{(sls_pkg::POS_W-1){1'b0}}, 1'b1};
	end

	assign push        = acc && (n != '0);
	assign bundle.toks = toks;
	assign bundle.cnt  = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pos_q   <= '0;
			begin_q <= '0;
			line_q  <= {{(sls_pkg::LINE_W-1){1'b0}}, 1'b1};
			cnt_q   <= '0;
			dot_q   <= '0;
		end else if (acc) begin
			mode_q  <= nxt_mode;
			pos_q   <= nxt_pos;
			begin_q <= nxt_begin;
			line_q  <= nxt_line;
			cnt_q   <= nxt_cnt;
			dot_q   <= nxt_dot;
		end
	end

	// Keyword window: written only for the identifier in progress.
	always_ff @(posedge clk) begin
		if (acc && win_we) win_q[win_idx] <= in_byte;
	end

	`SLS_CHECK_NEXT(a_eof_rewinds, acc && in_byte == CH_NUL,
		pos_q == '0 && line_q == {{(sls_pkg::LINE_W-1){1'b0}}, 1'b1} && mode_q == M_IDLE,
		"scanner did not rewind after end of source")
	`SLS_CHECK(a_begin_le_pos, begin_q <= pos_q, "token start past current position")

endmodule

@@ src/sls_queue.sv @@
// ----------------------------------------------------------------------------
// sls_queue
// Small FIFO of token groups between the scanner and the token emitter.
// ----------------------------------------------------------------------------
`include "script_lexical_scanner_defines.svh"

module sls_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sls_pkg::bundle_t wr_data,
	input  logic             pop,
	output sls_pkg::bundle_t head,
	output logic             full,
	output logic             empty
);

	sls_pkg::bundle_t            mem_q [sls_pkg::QDEPTH];
	logic [sls_pkg::QPTR_W-1:0]  wr_q, rd_q;
	logic [sls_pkg::QCNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == sls_pkg::QCNT_W'(sls_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_data;
	end

	`SLS_CHECK(a_no_overflow, push |-> !full, "push into a full token queue")
	`SLS_CHECK(a_no_underflow, pop |-> !empty, "pop from an empty token queue")
	`SLS_CHECK(a_head_nonempty, !empty |-> head.cnt != '0, "queued group holds no token")

endmodule

@@ src/sls_back.sv @@
// ----------------------------------------------------------------------------
// sls_back
// Drain queued token groups one token per cycle, while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module sls_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sls_pkg::bundle_t             head,
	input  logic                         empty,
	output logic                         pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [sls_pkg::TDATA_W-1:0]  m_tdata,
	output logic                         m_tlast
);

	logic                        valid_q, last_q, load, is_last;
	logic [sls_pkg::TOK_CW-1:0]  idx_q;
	sls_pkg::tok_t               tok_q;

	assign load    = !valid_q || m_tready;
	assign is_last = (idx_q == head.cnt - 2'd1);
	assign pop     = load && !empty && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				last_q <= is_last;
				idx_q  <= is_last ? '0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) tok_q <= head.toks[idx_q];
	end

	assign m_tvalid = valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{(sls_pkg::TDATA_W - sls_pkg::TOK_W){1'b0}}, tok_q};

endmodule
